// ----- rtl/hsb2rgb_pkg.sv -----
// Shared constants and types for the HSB to RGB color converter.
package hsb2rgb_pkg;

	localparam int COMP_BITS = 16;
	localparam int PROD_BITS = 2 * COMP_BITS;
	localparam int HUE6_BITS = COMP_BITS + 3;

	typedef logic [COMP_BITS-1:0] comp_t;
	typedef logic [PROD_BITS-1:0] prod_t;
	typedef logic [2:0]           sector_t;

	// All-ones code stands for 1.0.
	localparam comp_t FULL_SCALE = {COMP_BITS{1'b1}};

	localparam logic COLOR_KIND_RGB = 1'b0;
	localparam logic COLOR_KIND_HSB = 1'b1;

	localparam sector_t SECTOR_0 = 3'd0;
	localparam sector_t SECTOR_1 = 3'd1;
	localparam sector_t SECTOR_2 = 3'd2;
	localparam sector_t SECTOR_3 = 3'd3;
	localparam sector_t SECTOR_4 = 3'd4;
	localparam sector_t SECTOR_5 = 3'd5;

endpackage

// ----- rtl/hsb2rgb_if.sv -----
// Handshake interfaces for the color input channel and the RGB result channel.
interface hsb2rgb_color_if;
	logic                 valid;
	logic                 ready;
	logic                 color_kind;
	hsb2rgb_pkg::comp_t   comp_first;
	hsb2rgb_pkg::comp_t   comp_second;
	hsb2rgb_pkg::comp_t   comp_third;

	modport source (output valid, output color_kind, output comp_first,
		output comp_second, output comp_third, input ready);
	modport sink (input valid, input color_kind, input comp_first,
		input comp_second, input comp_third, output ready);
endinterface

interface hsb2rgb_rgb_if;
	logic                 valid;
	logic                 ready;
	hsb2rgb_pkg::comp_t   red_out;
	hsb2rgb_pkg::comp_t   green_out;
	hsb2rgb_pkg::comp_t   blue_out;

	modport source (output valid, output red_out, output green_out,
		output blue_out, input ready);
	modport sink (input valid, input red_out, input green_out,
		input blue_out, output ready);
endinterface

// ----- rtl/hsb_to_rgb_color_convert_core.sv -----
// Top level of the HSB to RGB color converter: a four-stage pipeline.
//
//   channel | direction | payload                                       | handshake
//   hsb     | in        | color_kind, comp_first, comp_second, comp_third | valid/ready
//   rgb     | out       | red_out, green_out, blue_out                    | valid/ready
//
// One item enters per clock cycle while no stall on rgb backs up to hsb. Its result
// passes through the stage registers one to four and shows on rgb from the last.
// The throughput of one item per cycle is set by the pipeline itself. The multiplies
// are spread out: the p product in stage one, sf and snf in stage two, q and t in three.
// Reset (arst_n low) clears the stage valid bits only; payload registers are not reset.
// A stall on rgb holds the output register; each stage keeps accepting while the
// stage after it is empty or moving, so bubbles close up and nothing is lost or repeated.
module hsb_to_rgb_color_convert_core (
	input  logic                 clk,
	input  logic                 arst_n,
	hsb2rgb_color_if.sink        hsb,
	hsb2rgb_rgb_if.source        rgb
);

	// Stage enables: a stage loads when it is empty or its contents move on.
	logic en_s1, en_s2, en_s3, en_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign en_s4 = !vld_s4 || rgb.ready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign hsb.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= hsb.valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
			if (en_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// Stage 1: hue times six splits into a sector and a fraction, and the
	// product behind p, brightness times (1.0 - saturation), is formed.
	logic [hsb2rgb_pkg::HUE6_BITS-1:0] hue6;
	assign hue6 = {1'b0, hsb.comp_first, 2'b00} + {2'b00, hsb.comp_first, 1'b0};

	logic                 kind_s1, zero_s1;
	hsb2rgb_pkg::comp_t   first_s1, sat_s1, bri_s1, frac_s1;
	hsb2rgb_pkg::sector_t sector_s1;
	hsb2rgb_pkg::prod_t   pprod_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1   <= hsb.color_kind;
			zero_s1   <= (hsb.comp_second == '0);
			first_s1  <= hsb.comp_first;
			sat_s1    <= hsb.comp_second;
			bri_s1    <= hsb.comp_third;
			sector_s1 <= hue6[hsb2rgb_pkg::HUE6_BITS-1:hsb2rgb_pkg::COMP_BITS];
			frac_s1   <= hue6[hsb2rgb_pkg::COMP_BITS-1:0];
			pprod_s1  <= hsb2rgb_pkg::prod_t'(hsb.comp_third)
				* hsb2rgb_pkg::prod_t'(hsb2rgb_pkg::FULL_SCALE - hsb.comp_second);
		end
	end

	// Stage 2: saturation scaled by the fraction and by its complement,
	// both truncated, and p from its product.
	localparam int SNF_BITS = hsb2rgb_pkg::PROD_BITS + 1;

	logic [hsb2rgb_pkg::COMP_BITS:0] frac_cmp;
	hsb2rgb_pkg::prod_t              sf_prod;
	logic [SNF_BITS-1:0]             snf_prod;
	hsb2rgb_pkg::comp_t              p_val;

	assign frac_cmp = {1'b1, {hsb2rgb_pkg::COMP_BITS{1'b0}}} - {1'b0, frac_s1};
	assign sf_prod  = hsb2rgb_pkg::prod_t'(sat_s1) * hsb2rgb_pkg::prod_t'(frac_s1);
	assign snf_prod = SNF_BITS'(sat_s1) * SNF_BITS'(frac_cmp);

	hsb2rgb_fs_div u_div_p (
		.prod (pprod_s1),
		.quot (p_val)
	);

	logic                 kind_s2, zero_s2;
	hsb2rgb_pkg::comp_t   first_s2, sat_s2, bri_s2, p_s2, sf_s2, snf_s2;
	hsb2rgb_pkg::sector_t sector_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2   <= kind_s1;
			zero_s2   <= zero_s1;
			first_s2  <= first_s1;
			sat_s2    <= sat_s1;
			bri_s2    <= bri_s1;
			sector_s2 <= sector_s1;
			p_s2      <= p_val;
			sf_s2     <= sf_prod[hsb2rgb_pkg::PROD_BITS-1:hsb2rgb_pkg::COMP_BITS];
			// The complement product never exceeds saturation times 2^N.
			snf_s2    <= snf_prod[hsb2rgb_pkg::PROD_BITS-1:hsb2rgb_pkg::COMP_BITS];
		end
	end

	// Stage 3: the products behind q and t.
	logic                 kind_s3, zero_s3;
	hsb2rgb_pkg::comp_t   first_s3, sat_s3, bri_s3, p_s3;
	hsb2rgb_pkg::sector_t sector_s3;
	hsb2rgb_pkg::prod_t   qprod_s3, tprod_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			kind_s3   <= kind_s2;
			zero_s3   <= zero_s2;
			first_s3  <= first_s2;
			sat_s3    <= sat_s2;
			bri_s3    <= bri_s2;
			sector_s3 <= sector_s2;
			p_s3      <= p_s2;
			qprod_s3  <= hsb2rgb_pkg::prod_t'(bri_s2)
				* hsb2rgb_pkg::prod_t'(hsb2rgb_pkg::FULL_SCALE - sf_s2);
			tprod_s3  <= hsb2rgb_pkg::prod_t'(bri_s2)
				* hsb2rgb_pkg::prod_t'(hsb2rgb_pkg::FULL_SCALE - snf_s2);
		end
	end

	// Stage 4: q and t, then the sector choice, into the output register.
	hsb2rgb_pkg::comp_t q_val, t_val;

	hsb2rgb_fs_div u_div_q (
		.prod (qprod_s3),
		.quot (q_val)
	);

	hsb2rgb_fs_div u_div_t (
		.prod (tprod_s3),
		.quot (t_val)
	);

	hsb2rgb_pkg::comp_t red_nx, green_nx, blue_nx;

	always_comb begin
		if (kind_s3 == hsb2rgb_pkg::COLOR_KIND_RGB) begin
			red_nx   = first_s3;
			green_nx = sat_s3;
			blue_nx  = bri_s3;
		end else if (zero_s3) begin
			// Zero saturation is gray at the brightness.
			red_nx   = bri_s3;
			green_nx = bri_s3;
			blue_nx  = bri_s3;
		end else begin
			case (sector_s3)
				hsb2rgb_pkg::SECTOR_0: begin
					red_nx = bri_s3; green_nx = t_val;  blue_nx = p_s3;
				end
				hsb2rgb_pkg::SECTOR_1: begin
					red_nx = q_val;  green_nx = bri_s3; blue_nx = p_s3;
				end
				hsb2rgb_pkg::SECTOR_2: begin
					red_nx = p_s3;   green_nx = bri_s3; blue_nx = t_val;
				end
				hsb2rgb_pkg::SECTOR_3: begin
					red_nx = p_s3;   green_nx = q_val;  blue_nx = bri_s3;
				end
				hsb2rgb_pkg::SECTOR_4: begin
					red_nx = t_val;  green_nx = p_s3;   blue_nx = bri_s3;
				end
				default: begin
					red_nx = bri_s3; green_nx = p_s3;   blue_nx = q_val;
				end
			endcase
		end
	end

	hsb2rgb_pkg::comp_t red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			red_s4   <= red_nx;
			green_s4 <= green_nx;
			blue_s4  <= blue_nx;
		end
	end

	assign rgb.valid     = vld_s4;
	assign rgb.red_out   = red_s4;
	assign rgb.green_out = green_s4;
	assign rgb.blue_out  = blue_s4;

endmodule

// ----- rtl/hsb2rgb_fs_div.sv -----
// Division of a product by the full-scale code (2^N - 1), truncating.
module hsb2rgb_fs_div (
	input  hsb2rgb_pkg::prod_t prod,
	output hsb2rgb_pkg::comp_t quot
);

	// For x below 2^(2N): floor(x / (2^N - 1)) = (y + (y >> N)) >> N with y = x + 1.
	logic [hsb2rgb_pkg::PROD_BITS:0] y;
	logic [hsb2rgb_pkg::PROD_BITS:0] sum;

	assign y    = {1'b0, prod} + {{hsb2rgb_pkg::PROD_BITS{1'b0}}, 1'b1};
	assign sum  = y + (y >> hsb2rgb_pkg::COMP_BITS);
	assign quot = sum[hsb2rgb_pkg::PROD_BITS-1:hsb2rgb_pkg::COMP_BITS];

endmodule

// ----- rtl/hsb2rgb_checker.sv -----
// Port-level assertions for the color converter, bound to its top level.
module hsb2rgb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input hsb2rgb_pkg::comp_t red,
	input hsb2rgb_pkg::comp_t green,
	input hsb2rgb_pkg::comp_t blue
);

	localparam logic [2:0] DEPTH = 3'd4;

	logic       in_acc, out_acc;
	logic [2:0] held_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items accepted and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 3'd0;
		end else begin
			held_q <= held_q + {2'b00, in_acc} - {2'b00, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled result changed or vanished");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= DEPTH)
		else $error("more items in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> held_q != 3'd0)
		else $error("result shown with no item in flight");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output is not stalled");

endmodule

bind hsb_to_rgb_color_convert_core hsb2rgb_checker u_hsb2rgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsb.valid),
	.in_ready  (hsb.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.red       (rgb.red_out),
	.green     (rgb.green_out),
	.blue      (rgb.blue_out)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the HSB to RGB color converter core.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	// One color as it crosses the hsb channel, and one result as it leaves on rgb.
	typedef struct packed {
		logic               color_kind;
		hsb2rgb_pkg::comp_t comp_first;
		hsb2rgb_pkg::comp_t comp_second;
		hsb2rgb_pkg::comp_t comp_third;
	} color_item_t;

	typedef struct packed {
		hsb2rgb_pkg::comp_t red_out;
		hsb2rgb_pkg::comp_t green_out;
		hsb2rgb_pkg::comp_t blue_out;
	} rgb_item_t;

	// The pipeline is four stages deep, so the drain wait at the end is plenty.
	localparam int DRAIN_CYCLES   = 16;
	// No accepted item on either side for this long means the block has hung.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 250;
	localparam int NUM_PHASES     = 4;
	localparam int REPORT_LIMIT   = 10;

	logic clk = 1'b0;
	logic arst_n;

	hsb2rgb_color_if hsb_ch();
	hsb2rgb_rgb_if   rgb_ch();

	hsb_to_rgb_color_convert_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsb    (hsb_ch),
		.rgb    (rgb_ch)
	);

	always #10 clk = ~clk;

	// Colors waiting to be offered, and the RGB values owed by the block, oldest first.
	color_item_t pending_colors[$];
	rgb_item_t   owed_rgb[$];

	// Idle and stall rates of the current phase, in percent.
	int unsigned sender_idle_pct = 0;
	int unsigned sink_stall_pct  = 0;

	int  fail_count   = 0;
	int  quiet_cycles = 0;
	bit  timed_out    = 1'b0;

	color_item_t next_color;
	color_item_t seen_color;
	rgb_item_t   seen_rgb;
	rgb_item_t   owed_head;
	bit          color_taken;
	bit          rgb_taken;

	// Converts one color the way the block must: kind 0 passes straight through,
	// kind 1 goes through the six-sector HSV formula with truncating products.
	function automatic rgb_item_t convert_color(color_item_t c);
		rgb_item_t            res;
		bit [63:0]            full, sat, bri, hue6, frac, sat_frac, sat_nfrac;
		bit [63:0]            p_val, q_val, t_val;
		hsb2rgb_pkg::comp_t   p, q, t, v;
		hsb2rgb_pkg::sector_t sec;
		full = 64'(hsb2rgb_pkg::FULL_SCALE);
		sat  = 64'(c.comp_second);
		bri  = 64'(c.comp_third);
		v    = c.comp_third;
		if (c.color_kind == hsb2rgb_pkg::COLOR_KIND_RGB) begin
			res = '{c.comp_first, c.comp_second, c.comp_third};
		end else if (c.comp_second == '0) begin
			res = '{v, v, v};
		end else begin
			hue6      = 64'(c.comp_first) * 64'd6;
			sec       = hsb2rgb_pkg::sector_t'(hue6 >> hsb2rgb_pkg::COMP_BITS);
			frac      = hue6 & full;
			sat_frac  = (sat * frac) >> hsb2rgb_pkg::COMP_BITS;
			sat_nfrac = (sat * ((64'd1 << hsb2rgb_pkg::COMP_BITS) - frac))
				>> hsb2rgb_pkg::COMP_BITS;
			p_val     = (bri * (full - sat)) / full;
			q_val     = (bri * (full - sat_frac)) / full;
			t_val     = (bri * (full - sat_nfrac)) / full;
			p = hsb2rgb_pkg::comp_t'(p_val);
			q = hsb2rgb_pkg::comp_t'(q_val);
			t = hsb2rgb_pkg::comp_t'(t_val);
			case (sec)
				hsb2rgb_pkg::SECTOR_0: res = '{v, t, p};
				hsb2rgb_pkg::SECTOR_1: res = '{q, v, p};
				hsb2rgb_pkg::SECTOR_2: res = '{p, v, t};
				hsb2rgb_pkg::SECTOR_3: res = '{p, q, v};
				hsb2rgb_pkg::SECTOR_4: res = '{t, p, v};
				default:               res = '{v, p, q};
			endcase
		end
		return res;
	endfunction

	// Component values lean on the edges: zero, full scale and tiny codes show up
	// far more often than a flat draw would give them.
	function automatic hsb2rgb_pkg::comp_t pick_component();
		int unsigned roll;
		roll = $urandom_range(15);
		if (roll < 2)
			return '0;
		else if (roll < 4)
			return hsb2rgb_pkg::FULL_SCALE;
		else if (roll == 4)
			return hsb2rgb_pkg::comp_t'($urandom_range(3));
		else
			return hsb2rgb_pkg::comp_t'($urandom_range(65535));
	endfunction

	// Hues mostly random, sometimes right on a sector boundary where the
	// fraction wraps and the sector choice changes.
	function automatic hsb2rgb_pkg::comp_t pick_hue();
		int unsigned sect;
		if ($urandom_range(7) == 0) begin
			sect = $urandom_range(5);
			return hsb2rgb_pkg::comp_t'((sect * 65536) / 6 + $urandom_range(2));
		end
		return pick_component();
	endfunction

	function automatic color_item_t pick_color();
		color_item_t c;
		// Three in four items are HSB, since that is where the arithmetic lives.
		c.color_kind  = ($urandom_range(3) != 0) ? hsb2rgb_pkg::COLOR_KIND_HSB
			: hsb2rgb_pkg::COLOR_KIND_RGB;
		c.comp_first  = pick_hue();
		c.comp_second = ($urandom_range(9) == 0) ? hsb2rgb_pkg::comp_t'(0) : pick_component();
		c.comp_third  = pick_component();
		return c;
	endfunction

	task automatic push_color(logic kind, hsb2rgb_pkg::comp_t first,
			hsb2rgb_pkg::comp_t second, hsb2rgb_pkg::comp_t third);
		pending_colors.push_back('{kind, first, second, third});
	endtask

	// Waits until every queued color has been taken and every result has come back.
	// Sampling on the falling edge keeps this clear of the clocked blocks.
	task automatic wait_drained();
		while ((pending_colors.size() != 0 || hsb_ch.valid || owed_rgb.size() != 0)
				&& !timed_out)
			@(negedge clk);
	endtask

	// Driver: offers the next queued color whenever the channel is free, holding it
	// until it is accepted. A random roll per cycle decides whether it idles instead.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsb_ch.valid       <= 1'b0;
			hsb_ch.color_kind  <= hsb2rgb_pkg::COLOR_KIND_RGB;
			hsb_ch.comp_first  <= '0;
			hsb_ch.comp_second <= '0;
			hsb_ch.comp_third  <= '0;
		end else if (!hsb_ch.valid || hsb_ch.ready) begin
			if (pending_colors.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_color = pending_colors.pop_front();
				hsb_ch.valid       <= 1'b1;
				hsb_ch.color_kind  <= next_color.color_kind;
				hsb_ch.comp_first  <= next_color.comp_first;
				hsb_ch.comp_second <= next_color.comp_second;
				hsb_ch.comp_third  <= next_color.comp_third;
			end else begin
				hsb_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: ready is rolled afresh every cycle at the phase's stall rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_ch.ready <= 1'b0;
		end else begin
			rgb_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Monitor: every accepted color adds its predicted RGB to the owed list, and every
	// accepted result is checked against the oldest entry. It also runs the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			color_taken = hsb_ch.valid && hsb_ch.ready;
			rgb_taken   = rgb_ch.valid && rgb_ch.ready;
			if (rgb_taken) begin
				seen_rgb = '{rgb_ch.red_out, rgb_ch.green_out, rgb_ch.blue_out};
				if (owed_rgb.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("Unexpected result r=%h g=%h b=%h with nothing owed",
							seen_rgb.red_out, seen_rgb.green_out, seen_rgb.blue_out);
				end else begin
					owed_head = owed_rgb.pop_front();
					if (seen_rgb.red_out !== owed_head.red_out
							|| seen_rgb.green_out !== owed_head.green_out
							|| seen_rgb.blue_out !== owed_head.blue_out) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("RGB mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
								owed_head.red_out, owed_head.green_out, owed_head.blue_out,
								seen_rgb.red_out, seen_rgb.green_out, seen_rgb.blue_out);
					end
				end
			end
			if (color_taken) begin
				seen_color = '{hsb_ch.color_kind, hsb_ch.comp_first, hsb_ch.comp_second,
					hsb_ch.comp_third};
				owed_rgb.push_back(convert_color(seen_color));
			end
			if (color_taken || rgb_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT)
				timed_out = 1'b1;
		end
	end

	// Idle and stall rates per phase: clean flow, a sluggish sender, a sluggish
	// receiver, and light idling on both sides at once.
	int unsigned phase_idle[NUM_PHASES]  = '{0, 60, 0, 8};
	int unsigned phase_stall[NUM_PHASES] = '{0, 0, 60, 8};

	initial begin
		// Reset is asserted from time zero; the reset branches of the driver and
		// receiver set everything the block sees.
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Direct RGB: the components must come through untouched, extremes included.
		push_color(hsb2rgb_pkg::COLOR_KIND_RGB, 16'h0000, 16'h0000, 16'h0000);
		push_color(hsb2rgb_pkg::COLOR_KIND_RGB, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_RGB, 16'hFFFF, 16'h0000, 16'h8000);
		push_color(hsb2rgb_pkg::COLOR_KIND_RGB, 16'h1234, 16'hABCD, 16'h0001);
		// Zero saturation gives gray at the brightness, whatever the hue.
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'h5555, 16'h0000, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'hFFFF, 16'h0000, 16'h0000);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'h0000, 16'h0000, 16'h1234);
		// Full saturation and brightness on both sides of each sector boundary (only just above
		// the one into sector three), plus the largest hue, which sits just short of the wrap back to red.
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd0,     16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd10922, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd10923, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd21845, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd21846, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd32768, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd43690, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd43691, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd54613, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd54614, 16'hFFFF, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'd65535, 16'hFFFF, 16'hFFFF);
		// Smallest nonzero saturation, zero and tiny brightness, a mid-range mix.
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'h8000, 16'h0001, 16'hFFFF);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'h3000, 16'hFFFF, 16'h0000);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'h2AAA, 16'hFFFF, 16'h0001);
		push_color(hsb2rgb_pkg::COLOR_KIND_HSB, 16'hC000, 16'h8000, 16'h8000);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			sender_idle_pct = phase_idle[ph];
			sink_stall_pct  = phase_stall[ph];
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				pending_colors.push_back(pick_color());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);

		if (timed_out)
			$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
		if (owed_rgb.size() != 0)
			$display("%0d expected results never arrived", owed_rgb.size());
		if (!timed_out && fail_count == 0 && owed_rgb.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
